// ----- design/mcls_pkg.sv -----
package mcls_pkg;

    // Default sample width, signed Q8.16
    localparam int SAMPLE_BITS_DEF = 24;

    // Configuration register indexes (byte address = 4 * index)
    localparam int CFG_ADDR_BITS = 3;
    localparam logic [0:0] REG_FOURTH_ORDER_MODE = 1'b0;

    localparam int NUM_SAMPLES = 5;

endpackage

// ----- design/mcls_div6.sv -----
module mcls_div6 #(
    parameter int AW = 28
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [AW-1:0]     dividend,
    output logic [AW-3:0]     quotient
);
    // Reciprocal multiply: q_est is floor(a/6) or one less, fixed by a single compare.
    localparam int S  = AW + 3;
    localparam int MW = AW + 1;
    localparam int PW = AW + MW;
    localparam logic [MW-1:0] RECIP = MW'((64'd1 << S) / 64'd6);

    logic [PW-1:0] prod_reg;
    logic [AW-1:0] a_reg;
    logic [AW-3:0] q_est;
    logic [AW:0]   six_q;
    logic [AW:0]   rem;
    logic          corr;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PW'(dividend) * PW'(RECIP);
            a_reg    <= dividend;
        end
    end

    always_comb begin
        q_est    = prod_reg[PW-1:S];
        six_q    = (AW+1)'({q_est, 2'b00}) + (AW+1)'({q_est, 1'b0});
        rem      = {1'b0, a_reg} - six_q;
        corr     = (rem >= (AW+1)'(6));
        quotient = q_est + (AW-2)'(corr);
    end

endmodule

// ----- design/mc_limited_slope_top.sv -----
// Monotonized-central slope limiter, plain or fourth-order re-limited.
// An accepted input passes the stage A, B, C and D registers in turn before m_tvalid rises.
// Throughput: one transaction per cycle; the four-stage pipeline advances
// whenever the output register is empty or being taken, and stalls as a whole otherwise.
// Reset (aresetn low, synchronous) clears all valid bits and fourth_order_mode.
module mc_limited_slope_top #(
    parameter int SAMPLE_BITS = mcls_pkg::SAMPLE_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,

    // APB-style configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mcls_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,

    // Input stream
    input  logic s_tvalid,
    output logic s_tready,
    // fields from bit 0 up: sample_minus_two, sample_minus_one, sample_center,
    // sample_plus_one, sample_plus_two (SAMPLE_BITS each), zero padding
    input  logic [((mcls_pkg::NUM_SAMPLES*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,

    // Result stream
    output logic m_tvalid,
    input  logic m_tready,
    // fields from bit 0 up: limited_slope (SAMPLE_BITS+3, signed Q.17), zero padding
    output logic [((SAMPLE_BITS+3+7)/8)*8-1:0] m_tdata
);
    import mcls_pkg::*;

    localparam int SW     = SAMPLE_BITS;
    localparam int LW     = SW + 3;     // limit magnitude
    localparam int NW     = SW + 5;     // signed fourth-order numerator
    localparam int AW     = SW + 4;     // |N| + 3
    localparam int QW     = AW - 2;     // quotient of the divide by six
    localparam int OUT_TW = ((SW + 3 + 7) / 8) * 8;

    // ------------------------------------------------------------------
    // Helpers: limit and plain MC slope of one three-sample centre
    // ------------------------------------------------------------------
    function automatic logic [LW-1:0] lim_of(
        input logic signed [SW-1:0] sm,
        input logic signed [SW-1:0] s0,
        input logic signed [SW-1:0] sp
    );
        logic [SW:0] dl;
        logic [SW:0] dr;
        logic [SW:0] al;
        logic [SW:0] ar;
        logic [SW:0] mn;
        logic        opp;
        dl  = {s0[SW-1], s0} - {sm[SW-1], sm};
        dr  = {sp[SW-1], sp} - {s0[SW-1], s0};
        al  = dl[SW] ? (~dl + 1'b1) : dl;
        ar  = dr[SW] ? (~dr + 1'b1) : dr;
        mn  = (al < ar) ? al : ar;
        // one-sided differences of strictly opposite sign clamp to zero
        opp = (dl[SW] && !dr[SW] && (dr != '0)) || (dr[SW] && !dl[SW] && (dl != '0));
        return opp ? '0 : {mn, 2'b00};
    endfunction

    function automatic logic signed [SW+1:0] mc_of(
        input logic signed [SW-1:0] sm,
        input logic signed [SW-1:0] s0,
        input logic signed [SW-1:0] sp
    );
        logic [SW:0]   dc;
        logic [SW:0]   adc;
        logic [LW-1:0] lim;
        logic [SW:0]   mag;
        dc  = {sp[SW-1], sp} - {sm[SW-1], sm};
        adc = dc[SW] ? (~dc + 1'b1) : dc;
        lim = lim_of(sm, s0, sp);
        mag = (lim < LW'(adc)) ? lim[SW:0] : adc;
        return dc[SW] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic mode_reg;
    logic cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[CFG_ADDR_BITS-1] == REG_FOURTH_ORDER_MODE);
    assign prdata  = cfg_sel ? {31'd0, mode_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            mode_reg <= pwdata[0];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances together
    // ------------------------------------------------------------------
    logic adv;
    logic va_reg, vb_reg, vc_reg, m_tvalid_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg       <= 1'b0;
            vb_reg       <= 1'b0;
            vc_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            va_reg       <= s_tvalid;
            vb_reg       <= va_reg;
            vc_reg       <= vb_reg;
            m_tvalid_reg <= vc_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: input register
    // ------------------------------------------------------------------
    logic signed [SW-1:0] m2_reg, m1_reg, c_reg, p1_reg, p2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            m2_reg <= s_tdata[0*SW +: SW];
            m1_reg <= s_tdata[1*SW +: SW];
            c_reg  <= s_tdata[2*SW +: SW];
            p1_reg <= s_tdata[3*SW +: SW];
            p2_reg <= s_tdata[4*SW +: SW];
        end
    end

    // ------------------------------------------------------------------
    // Stage B: differences, limit and fourth-order numerator
    // ------------------------------------------------------------------
    logic [SW:0]             dc_a;
    logic [SW:0]             adc_a;
    logic [LW-1:0]           lim_a;
    logic signed [SW+1:0]    dfm_a, dfp_a;
    logic signed [NW-1:0]    n_a;
    logic [NW-1:0]           an_a;
    logic [AW-1:0]           num_a;

    always_comb begin
        dc_a  = {p1_reg[SW-1], p1_reg} - {m1_reg[SW-1], m1_reg};
        adc_a = dc_a[SW] ? (~dc_a + 1'b1) : dc_a;
        lim_a = lim_of(m1_reg, c_reg, p1_reg);
        dfm_a = mc_of(m2_reg, m1_reg, c_reg);
        dfp_a = mc_of(c_reg, p1_reg, p2_reg);
        // N = 8*dcen - dfm - dfp, exact
        n_a   = (NW'($signed(dc_a)) <<< 3) - NW'(dfm_a) - NW'(dfp_a);
        an_a  = n_a[NW-1] ? (~n_a + 1'b1) : n_a;
        // add 3 so the floor divide by six rounds to nearest
        num_a = an_a[AW-1:0] + AW'(3);
    end

    logic          sgn_b_reg, mode_b_reg;
    logic [SW:0]   adc_b_reg;
    logic [LW-1:0] lim_b_reg;
    logic [AW-1:0] num_b_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            sgn_b_reg  <= dc_a[SW];
            mode_b_reg <= mode_reg;
            adc_b_reg  <= adc_a;
            lim_b_reg  <= lim_a;
            num_b_reg  <= num_a;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: divide by six (product register inside the divider)
    // ------------------------------------------------------------------
    logic [QW-1:0] quot_c;

    mcls_div6 #(
        .AW (AW)
    ) u_div6 (
        .aclk     (aclk),
        .en       (adv),
        .dividend (num_b_reg),
        .quotient (quot_c)
    );

    logic          sgn_c_reg, mode_c_reg;
    logic [SW:0]   adc_c_reg;
    logic [LW-1:0] lim_c_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            sgn_c_reg  <= sgn_b_reg;
            mode_c_reg <= mode_b_reg;
            adc_c_reg  <= adc_b_reg;
            lim_c_reg  <= lim_b_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: pick estimate, clamp to limit, apply sign of dcen
    // ------------------------------------------------------------------
    logic [LW-1:0]        est_d;
    logic [LW-1:0]        mag_d;
    logic signed [LW-1:0] res_d;
    logic signed [LW-1:0] res_reg;

    always_comb begin
        est_d = mode_c_reg ? LW'(quot_c) : LW'(adc_c_reg);
        mag_d = (lim_c_reg < est_d) ? lim_c_reg : est_d;
        // zero centre difference counts as positive
        res_d = sgn_c_reg ? -$signed(mag_d) : $signed(mag_d);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg <= res_d;
        end
    end

    assign m_tdata = OUT_TW'(res_reg[LW-1:0]);

endmodule

// ----- sim/slope_checker.sv -----
`timescale 1ns / 1ps

module slope_checker #(
    parameter int SAMPLE_BITS = mcls_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                                    aclk,
    input  logic                                                    aresetn,
    input  logic                                                    psel,
    input  logic                                                    penable,
    input  logic                                                    pwrite,
    input  logic [mcls_pkg::CFG_ADDR_BITS-1:0]                      paddr,
    input  logic [31:0]                                             pwdata,
    input  logic [31:0]                                             prdata,
    input  logic                                                    pready,
    input  logic                                                    s_tvalid,
    input  logic                                                    s_tready,
    input  logic [((mcls_pkg::NUM_SAMPLES*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                                                    m_tvalid,
    input  logic                                                    m_tready,
    input  logic [((SAMPLE_BITS+3+7)/8)*8-1:0]                      m_tdata,
    output int unsigned                                             fail_count,
    output int unsigned                                             pending
);
    import mcls_pkg::*;

    localparam int IN_W       = ((NUM_SAMPLES*SAMPLE_BITS+7)/8)*8;
    localparam int SLOPE_BITS = SAMPLE_BITS + 3;
    localparam logic [CFG_ADDR_BITS-1:0] MODE_ADDR =
        CFG_ADDR_BITS'(4*REG_FOURTH_ORDER_MODE);

    logic [SLOPE_BITS-1:0] expected_slopes [$];
    logic                  order_mode;

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // bound from the one-sided differences; zero when they point opposite ways
    function automatic longint side_bound(longint lo, longint mid, longint hi);
        longint dl, dr, ml, mr;
        dl = 4*(mid - lo);
        dr = 4*(hi - mid);
        if ((dl < 0 && dr > 0) || (dl > 0 && dr < 0))
            return 0;
        ml = magnitude(dl);
        mr = magnitude(dr);
        return (ml < mr) ? ml : mr;
    endfunction

    function automatic longint side_slope(longint lo, longint mid, longint hi);
        longint dc, bound, m;
        dc    = hi - lo;
        bound = side_bound(lo, mid, hi);
        m     = magnitude(dc);
        if (bound < m)
            m = bound;
        return (dc >= 0) ? m : -m;
    endfunction

    function automatic logic [SLOPE_BITS-1:0] predict_slope(logic [IN_W-1:0] word,
                                                             logic fourth);
        longint s [NUM_SAMPLES];
        longint dc, bound, est, num;
        foreach (s[k])
            s[k] = longint'($signed(word[k*SAMPLE_BITS +: SAMPLE_BITS]));
        dc    = s[3] - s[1];
        bound = side_bound(s[1], s[2], s[3]);
        if (fourth) begin
            // re-limit 4/3 dcen minus the neighbour slopes over six, rounded
            num = 8*dc - side_slope(s[0], s[1], s[2]) - side_slope(s[2], s[3], s[4]);
            est = (magnitude(num) + 3) / 6;
        end else begin
            est = magnitude(dc);
        end
        if (bound < est)
            est = bound;
        if (dc < 0)
            est = -est;
        return est[SLOPE_BITS-1:0];
    endfunction

    always @(posedge aclk) begin
        logic [SLOPE_BITS-1:0] want;
        if (!aresetn) begin
            order_mode = 1'b0;
            expected_slopes.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr == MODE_ADDR)
                        order_mode = pwdata[0];
                end else if (paddr == MODE_ADDR && prdata !== {31'b0, order_mode}) begin
                    $error("fourth_order_mode mismatch: expected %0d, actual %0d",
                           order_mode, prdata);
                    fail_count++;
                end
            end
            if (s_tvalid && s_tready)
                expected_slopes.push_back(predict_slope(s_tdata, order_mode));
            if (m_tvalid && m_tready) begin
                if (expected_slopes.size() == 0) begin
                    $error("limited_slope unexpected transaction: expected none, actual %0d",
                           $signed(m_tdata[SLOPE_BITS-1:0]));
                    fail_count++;
                end else begin
                    want = expected_slopes.pop_front();
                    if (m_tdata[SLOPE_BITS-1:0] !== want) begin
                        $error("limited_slope mismatch: expected %0d, actual %0d",
                               $signed(want), $signed(m_tdata[SLOPE_BITS-1:0]));
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_slopes.size();
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import mcls_pkg::*;

    localparam int SB              = SAMPLE_BITS_DEF;
    localparam int IN_W            = ((NUM_SAMPLES*SB+7)/8)*8;
    localparam int OUT_W           = ((SB+3+7)/8)*8;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 292;   // about 1750 random transactions in all
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 8;     // pipeline latency plus margin
    localparam int IDLE_LIMIT      = 5000;
    localparam longint SAMPLE_MAX  = (longint'(1) << (SB-1)) - 1;
    localparam longint SAMPLE_MIN  = -(longint'(1) << (SB-1));
    localparam logic [CFG_ADDR_BITS-1:0] MODE_ADDR   = CFG_ADDR_BITS'(4*REG_FOURTH_ORDER_MODE);
    localparam logic [CFG_ADDR_BITS-1:0] UNUSED_ADDR = MODE_ADDR + CFG_ADDR_BITS'(4);

    typedef longint stencil_t [NUM_SAMPLES];

    logic                     aclk;
    logic                     aresetn;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     s_tvalid;
    logic                     s_tready;
    // fields from bit 0 up: sample_minus_two, sample_minus_one, sample_center,
    // sample_plus_one, sample_plus_two
    logic [IN_W-1:0]          s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    // fields from bit 0 up: limited_slope, zero padding
    logic [OUT_W-1:0]         m_tdata;

    int unsigned fail_count;
    int unsigned pending;
    int          idle_cycles = 0;
    bit          hold_off_req = 1'b0;

    // Corner stencils, each run once with the plain limiter and once in fourth-order mode
    stencil_t corner_cases [12] = '{
        '{0, 0, 0, 0, 0},
        '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX},
        '{SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN},
        '{SAMPLE_MIN, SAMPLE_MIN, 0, SAMPLE_MAX, SAMPLE_MAX},        // steepest rise
        '{SAMPLE_MAX, SAMPLE_MAX, 0, SAMPLE_MIN, SAMPLE_MIN},        // steepest fall
        '{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX},
        '{SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN},
        '{0, 100, 100, 500, 900},                                    // flat left side
        '{-7, 5, 10, 5, -7},                                         // zero centre difference
        '{-3, -1, 0, 2, 6},                                          // rounding tie
        '{9, 2, 1, -3, -20},                                         // falling, rounded
        '{SAMPLE_MIN, -1, 0, 1, SAMPLE_MAX}                          // wild outer cells
    };

    // One register per phase; upper bits set to show that only bit 0 counts
    logic [31:0] phase_modes [PHASES] = '{
        32'h0000_0003, 32'h0000_0000, 32'hFFFF_FFFF,
        32'hFFFF_FFFE, 32'h0000_0001, 32'h0000_0000
    };

    mc_limited_slope_top u_top (.*);

    slope_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly back-to-back, sometimes a short gap, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random stencil: mostly smooth runs that keep the limiter busy, some noise and corners
    function automatic stencil_t random_stencil();
        stencil_t st;
        int       kind;
        int       scale;
        bit       falling;
        longint   v, step;
        kind = $urandom_range(0, 99);
        if (kind < 20) begin
            foreach (st[k])
                st[k] = longint'($signed(SB'($urandom)));
        end else if (kind < 30) begin
            foreach (st[k]) begin
                case ($urandom_range(0, 4))
                    0:       st[k] = SAMPLE_MAX;
                    1:       st[k] = SAMPLE_MIN;
                    2:       st[k] = 0;
                    3:       st[k] = -1;
                    default: st[k] = 1;
                endcase
            end
        end else begin
            scale   = $urandom_range(0, 22);
            falling = $urandom_range(0, 1);
            if ($urandom_range(0, 3) == 0)
                v = longint'($urandom_range(0, 64)) - 32;
            else
                v = longint'($signed(SB'($urandom)));
            foreach (st[k]) begin
                st[k] = v;
                step  = longint'($urandom_range(0, 32'd1 << scale));
                // occasional kink breaks monotonicity
                if (falling ^ ($urandom_range(0, 7) == 0))
                    step = -step;
                v = v + step;
                if (v > SAMPLE_MAX)
                    v = SAMPLE_MAX;
                else if (v < SAMPLE_MIN)
                    v = SAMPLE_MIN;
            end
        end
        return st;
    endfunction

    // Offer one transaction after an optional gap; return at the falling edge after acceptance
    task automatic send_stencil(input stencil_t st, input int gap);
        logic [IN_W-1:0] word;
        word = '0;
        foreach (st[k])
            word[k*SB +: SB] = SB'(st[k]);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Setup and access phase, then the bus is left idle before the task returns
    task automatic apb_access(input logic write, input logic [CFG_ADDR_BITS-1:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // Drain the pipeline, write the given address, read back the mode register
    task automatic configure(input logic [CFG_ADDR_BITS-1:0] addr, input logic [31:0] data);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        apb_access(1'b1, addr, data);
        apb_access(1'b0, MODE_ADDR, '0);
    endtask

    // Stimulus: directed corners in both modes, then random phases
    initial begin
        stencil_t st;
        int       gap;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        aresetn  = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // check the reset value of the mode register
        apb_access(1'b0, MODE_ADDR, '0);
        foreach (corner_cases[i])
            send_stencil(corner_cases[i], pick_gap());
        configure(MODE_ADDR, 32'h1);
        foreach (corner_cases[i])
            send_stencil(corner_cases[i], pick_gap());

        for (int ph = 0; ph < PHASES; ph++) begin
            configure(MODE_ADDR, phase_modes[ph]);
            // a write to an unmapped address must leave the mode alone
            if (ph == 2)
                configure(UNUSED_ADDR, 32'h0);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // stall the result side for a long stretch while offering back-to-back
                if (ph == 1 && i == 120)
                    hold_off_req = 1'b1;
                // hold the input until every outstanding result is out
                if (ph == 3 && i == 150) begin
                    s_tvalid <= 1'b0;
                    wait (pending == 0);
                    @(negedge aclk);
                end
                st  = random_stencil();
                gap = pick_gap();
                if ((ph == 1 && i >= 120 && i < 160) || ph == 4)
                    gap = 0;
                send_stencil(st, gap);
            end
        end

        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Result side: random ready segments, plus the requested long hold-off
    initial begin
        int seg_left;
        int r;
        bit hold_done;
        seg_left  = 0;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
                seg_left  = 0;
            end else begin
                if (seg_left == 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 50) begin
                        m_tready <= 1'b1;
                        seg_left = $urandom_range(1, 20);
                    end else if (r < 85) begin
                        m_tready <= 1'b0;
                        seg_left = $urandom_range(1, 3);
                    end else if (r < 95) begin
                        m_tready <= 1'b1;
                        seg_left = $urandom_range(100, 300);
                    end else begin
                        m_tready <= 1'b0;
                        seg_left = $urandom_range(15, 60);
                    end
                end
                seg_left--;
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ----- filelist.f -----
design/mcls_pkg.sv
design/mcls_div6.sv
design/mc_limited_slope_top.sv
sim/slope_checker.sv
sim/testbench.sv
